[rtl/core/epx_pkg.sv]
// Shared types and constants of the 2x pixel-art upscaler.
// No dependencies; imported by the interfaces and every module of the block.
`default_nettype none

package epx_pkg;

  // Input word kinds
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // Configuration register map
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 13;
  localparam int WIDTH_REG_BITS  = 9;
  localparam int HEIGHT_REG_BITS = 13;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 9'd8;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd8;
  localparam int MAX_HEIGHT = 4096;

  // Result position fields
  localparam int COL_OUT_BITS = 8;
  localparam int ROW_BITS     = 12;

  // Neighborhood slots: center, up, right, left, down
  localparam int NB_COUNT = 5;
  localparam int NB_P = 0;
  localparam int NB_A = 1;
  localparam int NB_B = 2;
  localparam int NB_C = 3;
  localparam int NB_D = 4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  typedef struct packed {
    logic [COL_OUT_BITS-1:0] block_column;
    logic [ROW_BITS-1:0]     block_row;
    logic                    last_block;
  } epx_tag_t;

endpackage

`default_nettype wire

[rtl/core/epx_in_if.sv]
// Source pixel channel: valid/ready handshake with mode and pixel payload.
// Depends on epx_pkg.
`default_nettype none

interface epx_in_if
  import epx_pkg::*;
#(
  parameter int PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, output mode, output pixel_value, input ready);
  modport sink   (input valid, input mode, input pixel_value, output ready);
endinterface

`default_nettype wire

[rtl/core/epx_out_if.sv]
// Result block channel: valid/ready handshake with the 2x2 block and its position.
// Depends on epx_pkg.
`default_nettype none

interface epx_out_if
  import epx_pkg::*;
#(
  parameter int PIXEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [PIXEL_BITS-1:0]   top_left;
  logic [PIXEL_BITS-1:0]   top_right;
  logic [PIXEL_BITS-1:0]   bottom_left;
  logic [PIXEL_BITS-1:0]   bottom_right;
  logic [COL_OUT_BITS-1:0] block_column;
  logic [ROW_BITS-1:0]     block_row;
  logic                    last_block;

  modport source (
    output valid, output top_left, output top_right, output bottom_left,
    output bottom_right, output block_column, output block_row, output last_block,
    input ready
  );
  modport sink (
    input valid, input top_left, input top_right, input bottom_left,
    input bottom_right, input block_column, input block_row, input last_block,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/epx_front.sv]
// Front end: accepts words, tracks raster position, owns the two line stores
// and gathers each block's neighborhood. Depends on epx_pkg and epx_in_if.
`default_nettype none

module epx_front
  import epx_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
  epx_in_if.sink                             pix_in,
  input  wire logic                          push_ready,
  output logic                               push_valid,
  output epx_tag_t                           push_tag,
  output logic [NB_COUNT-1:0][PIXEL_BITS-1:0] push_nbr
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = WW + 1;

  logic [WIDTH_REG_BITS-1:0]  width_reg;
  logic [HEIGHT_REG_BITS-1:0] height_reg;
  logic [WW-1:0]              eff_w;
  logic [HEIGHT_REG_BITS-1:0] eff_h;

  logic [CW-1:0]       col, col_next;
  logic [ROW_BITS-1:0] row, row_next;
  logic                draining, draining_next;
  logic [PIXEL_BITS-1:0] left;

  logic [PIXEL_BITS-1:0] prev_mem  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] prev_q, prev1_q, older_q;
  logic [CW-1:0]         rd1_addr;

  logic accept, step_pix, step_drain, last_col, last_row;
  logic [ROW_BITS-1:0]   blk_row;
  logic [PIXEL_BITS-1:0] p, a, b, c, d;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_reg  <= WIDTH_REG_BITS'(cfg_data);
        REG_IMAGE_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp out-of-range sizes
  always_comb begin
    if (width_reg == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_reg);
    end
    if (height_reg == '0) begin
      eff_h = HEIGHT_REG_BITS'(1);
    end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
      eff_h = HEIGHT_REG_BITS'(MAX_HEIGHT);
    end else begin
      eff_h = height_reg;
    end
  end

  assign pix_in.ready = push_ready;
  assign accept     = pix_in.valid && pix_in.ready;
  assign step_pix   = accept && (pix_in.mode == MODE_PIXEL) && !draining;
  assign step_drain = accept && (pix_in.mode == MODE_DRAIN) && draining;

  assign last_col = (LW'(col) + LW'(1)) >= LW'(eff_w);
  assign last_row = (HEIGHT_REG_BITS'(row) + HEIGHT_REG_BITS'(1)) >= eff_h;

  // Neighborhood of the block at the current position
  assign blk_row = draining ? row : row - ROW_BITS'(1);
  assign p = prev_q;
  assign a = (blk_row != '0) ? older_q : p;
  assign b = last_col ? p : prev1_q;
  assign c = (col != '0) ? left : p;
  assign d = draining ? p : pix_in.pixel_value;

  assign push_valid             = step_drain || (step_pix && (row != '0));
  assign push_tag.block_column  = COL_OUT_BITS'(col);
  assign push_tag.block_row     = blk_row;
  assign push_tag.last_block    = draining && last_col;
  assign push_nbr[NB_P] = p;
  assign push_nbr[NB_A] = a;
  assign push_nbr[NB_B] = b;
  assign push_nbr[NB_C] = c;
  assign push_nbr[NB_D] = d;

  // Position update; a register write restarts the frame
  always_comb begin
    col_next      = col;
    row_next      = row;
    draining_next = draining;
    if (rst || cfg_we) begin
      col_next      = '0;
      row_next      = '0;
      draining_next = 1'b0;
    end else if (step_pix) begin
      if (last_col) begin
        col_next = '0;
        if (last_row) begin
          draining_next = 1'b1;
        end else begin
          row_next = row + ROW_BITS'(1);
        end
      end else begin
        col_next = col + CW'(1);
      end
    end else if (step_drain) begin
      if (last_col) begin
        col_next      = '0;
        row_next      = '0;
        draining_next = 1'b0;
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      draining <= 1'b0;
    end else begin
      col      <= col_next;
      row      <= row_next;
      draining <= draining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_pix || step_drain) begin
      left <= p;
    end
  end

  // Line stores: read ahead at the next position, forward this cycle's write
  assign rd1_addr = col_next + CW'(1);

  always_ff @(posedge clk) begin
    if (step_pix) begin
      prev_mem[col]  <= pix_in.pixel_value;
      older_mem[col] <= p;
    end
    prev_q  <= (step_pix && (col_next == col)) ? pix_in.pixel_value : prev_mem[col_next];
    prev1_q <= (step_pix && (rd1_addr == col)) ? pix_in.pixel_value : prev_mem[rd1_addr];
    older_q <= (step_pix && (col_next == col)) ? p : older_mem[col_next];
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    LW'(col) < LW'(eff_w))
    else $error("column position beyond image width");

  a_drain_on_last_row: assert property (@(posedge clk) disable iff (rst)
    draining |-> (HEIGHT_REG_BITS'(row) + HEIGHT_REG_BITS'(1)) == eff_h)
    else $error("draining while not on the last row");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_tag.last_block) |=> (!draining && col == '0 && row == '0))
    else $error("frame did not restart after the final block");

endmodule

`default_nettype wire

[rtl/core/epx_queue.sv]
// Short word queue between front and back so each side stalls on its own.
// Depends on epx_pkg.
`default_nettype none

module epx_queue
  import epx_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push_valid,
  input  wire epx_tag_t                       push_tag,
  input  wire logic [NB_COUNT-1:0][PIXEL_BITS-1:0] push_nbr,
  output logic                                push_ready,
  output logic                                head_valid,
  output epx_tag_t                            head_tag,
  output logic [NB_COUNT-1:0][PIXEL_BITS-1:0] head_nbr,
  input  wire logic                           pop
);

  epx_tag_t                            tag_mem [QUEUE_DEPTH];
  logic [NB_COUNT-1:0][PIXEL_BITS-1:0] nbr_mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic push, do_pop;

  assign push_ready = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign push       = push_valid && push_ready;
  assign do_pop     = pop && head_valid;
  assign head_tag   = tag_mem[rd_ptr];
  assign head_nbr   = nbr_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      tag_mem[wr_ptr] <= push_tag;
      nbr_mem[wr_ptr] <= push_nbr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("word offered to a full queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

`default_nettype wire

[rtl/core/epx_back.sv]
// Back end: applies the EPX rules to the queue head and holds the result
// in an output register. Depends on epx_pkg and epx_out_if.
`default_nettype none

module epx_back
  import epx_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           head_valid,
  input  wire epx_tag_t                       head_tag,
  input  wire logic [NB_COUNT-1:0][PIXEL_BITS-1:0] head_nbr,
  output logic                                pop,
  epx_out_if.source                           blk_out
);

  logic [PIXEL_BITS-1:0] p, a, b, c, d;
  logic [PIXEL_BITS-1:0] tl, tr, bl, br;
  logic out_valid;

  assign p = head_nbr[NB_P];
  assign a = head_nbr[NB_A];
  assign b = head_nbr[NB_B];
  assign c = head_nbr[NB_C];
  assign d = head_nbr[NB_D];

  assign tl = (c == a && c != d && a != b) ? a : p;
  assign tr = (a == b && a != c && b != d) ? b : p;
  assign bl = (d == c && d != b && c != a) ? c : p;
  assign br = (b == d && b != a && d != c) ? d : p;

  // Load the output register when it is empty or being taken
  assign pop = head_valid && (!out_valid || blk_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (blk_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      blk_out.top_left     <= tl;
      blk_out.top_right    <= tr;
      blk_out.bottom_left  <= bl;
      blk_out.bottom_right <= br;
      blk_out.block_column <= head_tag.block_column;
      blk_out.block_row    <= head_tag.block_row;
      blk_out.last_block   <= head_tag.last_block;
    end
  end

  assign blk_out.valid = out_valid;

endmodule

`default_nettype wire

[rtl/core/epx_scale2x_upscaler.sv]
// Channel    Dir  Handshake     Payload
// pix_in     in   valid/ready   mode, pixel_value
// blk_out    out  valid/ready   top_left..bottom_right, block_column, block_row, last_block
// cfg        in   cfg_we        cfg_index, cfg_data (image_width, image_height)
//
// One word per clock while the queue has room; the block for an accepted word is
// written to a queue entry, then passes into the output register.
// The line stores are read one position ahead with same-cycle write forwarding.
// Reset clears position, queue and output valid; line store contents are
// not cleared and no clearing pass runs.
// pix_in.ready drops only while the four-word queue is full (blk_out stalled).
`default_nettype none

module epx_scale2x_upscaler
  import epx_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  epx_in_if.sink                         pix_in,
  epx_out_if.source                      blk_out
);

  logic                                push_valid, push_ready;
  epx_tag_t                            push_tag;
  logic [NB_COUNT-1:0][PIXEL_BITS-1:0] push_nbr;
  logic                                head_valid, pop;
  epx_tag_t                            head_tag;
  logic [NB_COUNT-1:0][PIXEL_BITS-1:0] head_nbr;

  epx_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_in     (pix_in),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_tag   (push_tag),
    .push_nbr   (push_nbr)
  );

  epx_queue #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_tag   (push_tag),
    .push_nbr   (push_nbr),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_tag   (head_tag),
    .head_nbr   (head_nbr),
    .pop        (pop)
  );

  epx_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_tag   (head_tag),
    .head_nbr   (head_nbr),
    .pop        (pop),
    .blk_out    (blk_out)
  );

endmodule

`default_nettype wire

[bench/epx_scale2x_upscaler_test.sv]
// Self-checking bench for the 2x pixel-art upscaler: streams images through the
// pixel channel, predicts every 2x2 block in a scoreboard and checks the outputs.
// Depends on epx_pkg, epx_in_if, epx_out_if and epx_scale2x_upscaler.

class block_tracker;
  localparam int LINE_DEPTH = 256;
  localparam int HEIGHT_CAP = 4096;
  localparam int REPORT_CAP = 30;

  typedef struct packed {
    logic [7:0]  top_left;
    logic [7:0]  top_right;
    logic [7:0]  bottom_left;
    logic [7:0]  bottom_right;
    logic [7:0]  block_column;
    logic [11:0] block_row;
    logic        last_block;
  } block_t;

  logic [8:0]  width_reg;
  logic [12:0] height_reg;
  logic [7:0]  prev_line [LINE_DEPTH];
  logic [7:0]  older_line [LINE_DEPTH];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned drain_pos;
  logic [7:0]  left_hold;
  bit          draining;
  block_t      due_blocks [$];
  int unsigned errors;
  int unsigned blocks_checked;
  int unsigned frames_done;
  int unsigned live_words;
  int unsigned ignored_words;

  function new();
    width_reg = epx_pkg::WIDTH_RESET;
    height_reg = epx_pkg::HEIGHT_RESET;
    foreach (prev_line[i]) begin
      prev_line[i] = '0;
      older_line[i] = '0;
    end
    restart_frame();
  endfunction

  function void restart_frame();
    col_pos = 0;
    row_pos = 0;
    drain_pos = 0;
    left_hold = '0;
    draining = 1'b0;
  endfunction

  function int pending();
    return due_blocks.size();
  endfunction

  // Any register write restarts the frame; line contents survive.
  function void write_reg(input logic [epx_pkg::CFG_INDEX_BITS-1:0] idx,
                          input logic [epx_pkg::CFG_DATA_BITS-1:0] data);
    if (idx == epx_pkg::REG_IMAGE_WIDTH) begin
      width_reg = data[8:0];
    end else begin
      height_reg = data;
    end
    restart_frame();
  endfunction

  function block_t scale_block(input logic [7:0] ctr, up, rt, lf, dn,
                               input int unsigned col, row, input bit last);
    block_t blk;
    blk.top_left     = (lf == up && lf != dn && up != rt) ? up : ctr;
    blk.top_right    = (up == rt && up != lf && rt != dn) ? rt : ctr;
    blk.bottom_left  = (dn == lf && dn != rt && lf != up) ? lf : ctr;
    blk.bottom_right = (rt == dn && rt != up && dn != lf) ? dn : ctr;
    blk.block_column = 8'(col);
    blk.block_row    = 12'(row);
    blk.last_block   = last;
    return blk;
  endfunction

  // Advance the frame by one accepted word and queue the block it releases.
  function void take_word(input logic mode, input logic [7:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    logic [7:0] ctr;
    logic [7:0] up;
    logic [7:0] rt;
    logic [7:0] lf;
    bit last;
    w = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_CAP) ? HEIGHT_CAP : height_reg);
    if (mode == epx_pkg::MODE_DRAIN) begin
      if (!draining) begin
        ignored_words++;
        return;
      end
      live_words++;
      x = (drain_pos >= w) ? w - 1 : drain_pos;
      ctr = prev_line[x];
      up = (row_pos > 0) ? older_line[x] : ctr;
      rt = (x + 1 < w) ? prev_line[x + 1] : ctr;
      lf = (x > 0) ? prev_line[x - 1] : ctr;
      last = (x + 1 >= w);
      due_blocks.push_back(scale_block(ctr, up, rt, lf, ctr, x, row_pos, last));
      if (last) begin
        restart_frame();
        frames_done++;
      end else begin
        drain_pos = x + 1;
      end
    end else begin
      if (draining) begin
        ignored_words++;
        return;
      end
      live_words++;
      x = (col_pos >= w) ? w - 1 : col_pos;
      ctr = prev_line[x];
      if (row_pos > 0) begin
        up = (row_pos > 1) ? older_line[x] : ctr;
        rt = (x + 1 < w) ? prev_line[x + 1] : ctr;
        lf = (x > 0) ? left_hold : ctr;
        due_blocks.push_back(scale_block(ctr, up, rt, lf, pix, x, row_pos - 1, 1'b0));
      end
      left_hold = ctr;
      older_line[x] = ctr;
      prev_line[x] = pix;
      if (x + 1 >= w) begin
        col_pos = 0;
        left_hold = '0;
        if (row_pos + 1 >= h) begin
          draining = 1'b1;
          drain_pos = 0;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos = x + 1;
      end
    end
  endfunction

  function void compare_field(input string name, input logic [11:0] want_v, got_v);
    if (got_v !== want_v) begin
      errors++;
      if (errors <= REPORT_CAP) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      end
    end
  endfunction

  function void check_block(input block_t seen);
    block_t want;
    if (due_blocks.size() == 0) begin
      errors++;
      if (errors <= REPORT_CAP) begin
        $display("%0t: block with none expected, actual col %0d row %0d", $time,
                 seen.block_column, seen.block_row);
      end
      return;
    end
    want = due_blocks.pop_front();
    blocks_checked++;
    compare_field("top_left", want.top_left, seen.top_left);
    compare_field("top_right", want.top_right, seen.top_right);
    compare_field("bottom_left", want.bottom_left, seen.bottom_left);
    compare_field("bottom_right", want.bottom_right, seen.bottom_right);
    compare_field("block_column", want.block_column, seen.block_column);
    compare_field("block_row", want.block_row, seen.block_row);
    compare_field("last_block", want.last_block, seen.last_block);
  endfunction
endclass

module epx_scale2x_upscaler_test;
  import epx_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_SLACK  = 4;
  localparam int RANDOM_WORDS = 200;

  // Corner-case images, raster order: the first hits top-left and bottom-right
  // replacement around its center, the second top-right and bottom-left.
  localparam logic [0:8][7:0] DIAG_IMAGE = {
    8'd0, 8'd1, 8'd0,
    8'd1, 8'd255, 8'd2,
    8'd0, 8'd2, 8'd0
  };
  localparam logic [0:8][7:0] ANTI_IMAGE = {
    8'd255, 8'd1, 8'd255,
    8'd2, 8'd128, 8'd1,
    8'd255, 8'd2, 8'd255
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 15;
  int unsigned stall_pct = 15;
  int unsigned reg_writes = 0;
  int unsigned cur_width = WIDTH_RESET;
  int unsigned cur_height = HEIGHT_RESET;
  block_tracker sb;

  epx_in_if  #(.PIXEL_BITS(8)) in_ch ();
  epx_out_if #(.PIXEL_BITS(8)) out_ch ();

  epx_scale2x_upscaler #(.MAX_WIDTH(256), .PIXEL_BITS(8)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (in_ch),
    .blk_out   (out_ch)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      sb.take_word(in_ch.mode, in_ch.pixel_value);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_block({out_ch.top_left, out_ch.top_right, out_ch.bottom_left,
                      out_ch.bottom_right, out_ch.block_column, out_ch.block_row,
                      out_ch.last_block});
    end
  end

  // Hold valid low for a random gap, then present the word until it is taken.
  task automatic send_word(input logic mode, input logic [7:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.pixel_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(value);
    @(posedge clk);
    sb.write_reg(idx, CFG_DATA_BITS'(value));
    cfg_we <= 1'b0;
    @(posedge clk);
    // Track the register as stored, upper bits of the word dropped
    if (idx == REG_IMAGE_WIDTH) begin
      cur_width = value & 32'h1FF;
    end else begin
      cur_height = value & 32'h1FFF;
    end
    reg_writes++;
  endtask

  // Wait out every queued block plus the pipeline, so the block is idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Send the first `words` words of a w x h frame (pixels, then drain ticks),
  // sprinkled with words the block must drop.
  task automatic run_frame(input int unsigned w, h, words, noise_pct);
    logic [7:0] palette [4];
    int unsigned k;
    int unsigned pixels;
    pixels = w * h;
    foreach (palette[i]) begin
      palette[i] = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                            : 8'($urandom_range(255));
    end
    for (k = 0; k < words; k++) begin
      if ($urandom_range(99) < noise_pct) begin
        send_word((k < pixels) ? MODE_DRAIN : MODE_PIXEL, 8'($urandom_range(255)));
      end
      if (k < pixels) begin
        send_word(MODE_PIXEL, ($urandom_range(99) < 85) ? palette[$urandom_range(3)]
                                                        : 8'($urandom_range(255)));
      end else begin
        send_word(MODE_DRAIN, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: stopped after %0d cycles with %0d blocks outstanding",
             $time, cycle_count, sb.pending());
    $display("FAIL epx_scale2x_upscaler");
    $finish;
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned phase;
    int unsigned base_words;
    sb = new();
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_PIXEL;
    in_ch.pixel_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: stray drain tick, then a full 8x8 frame.
    send_word(MODE_DRAIN, 8'hA5);
    run_frame(8, 8, 72, 0);
    settle();

    // Zero width and height act as a single pixel; drop the pixel while draining.
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    send_word(MODE_PIXEL, 8'hFF);
    send_word(MODE_PIXEL, 8'h00);
    send_word(MODE_DRAIN, 8'h00);
    settle();

    // 3x3 frames back to back; the high bits of the width word are dropped.
    write_reg(REG_IMAGE_WIDTH, 13'h1E03);
    write_reg(REG_IMAGE_HEIGHT, 3);
    for (int i = 0; i < 9; i++) send_word(MODE_PIXEL, DIAG_IMAGE[i]);
    send_word(MODE_DRAIN, 8'h00);
    send_word(MODE_DRAIN, 8'hFF);
    send_word(MODE_PIXEL, 8'h77);
    send_word(MODE_DRAIN, 8'h00);
    for (int i = 0; i < 9; i++) send_word(MODE_PIXEL, ANTI_IMAGE[i]);
    repeat (3) send_word(MODE_DRAIN, 8'h00);

    phase = 0;
    base_words = sb.live_words;
    while (sb.live_words - base_words < RANDOM_WORDS) begin
      settle();
      idle_pct = (phase % 6 == 3) ? 0 : 15;
      stall_pct = idle_pct;
      case ($urandom_range(2))
        0: write_reg(REG_IMAGE_WIDTH, ($urandom_range(9) == 0) ? 0 :
                     (($urandom_range(3) == 0) ? $urandom_range(17, 48)
                                               : $urandom_range(1, 16)));
        1: write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 6));
        default: begin
          write_reg(REG_IMAGE_WIDTH, $urandom_range(1, 16));
          write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 6));
        end
      endcase
      w = (cur_width == 0) ? 1 : cur_width;
      h = (cur_height == 0) ? 1 : cur_height;
      repeat ($urandom_range(1, 3)) run_frame(w, h, w * h + w, 8);
      // Break off some phases mid-frame; the next register write restarts.
      if ($urandom_range(99) < 20) run_frame(w, h, $urandom_range(1, w * h + w - 1), 8);
      phase++;
    end

    // Widest frame, reached through a clamped width value.
    settle();
    idle_pct = 15;
    stall_pct = 15;
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 1);
    run_frame(256, 1, 512, 5);
    settle();

    $display("Sent %0d words (%0d dropped by design) over %0d register writes;",
             sb.live_words + sb.ignored_words, sb.ignored_words, reg_writes);
    $display("compared %0d blocks across %0d completed frames, %0d errors.",
             sb.blocks_checked, sb.frames_done, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS epx_scale2x_upscaler");
    end else begin
      $display("FAIL epx_scale2x_upscaler");
    end
    $finish;
  end
endmodule
